// File: hw/rtl/ooks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ooks_pkg
// shared constants and types of the ook energy bit slicer
// ----------------------------------------------------------------------------
package ooks_pkg;

  localparam int unsigned SAMPLES_PER_BIT = 32;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned ENERGY_W = 16;
  localparam int unsigned MAX_MAG  = 32768;
  localparam int unsigned SUM_W    = $clog2(SAMPLES_PER_BIT * MAX_MAG + 1);
  localparam int unsigned CNT_W    = $clog2(SAMPLES_PER_BIT + 1);
  localparam int unsigned FLOOR_SH = 4;
  localparam int unsigned FLOOR_W  = ENERGY_W + FLOOR_SH;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BIT - 1);

  typedef struct packed {
    logic                valid;
    logic [ENERGY_W-1:0] avg;
  } ooks_avg_t;

endpackage : ooks_pkg
`default_nettype wire

// File: hw/rtl/ook_energy_bit_slicer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ook_energy_bit_slicer_top
// ook envelope detector: per-bit energy average against an adaptive floor
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_       slave      tdata[7:0] i_sample, tdata[15:8] q_sample
// out_      master     tdata[0] bit_value, [16:1] energy_average, [32:17] floor_level
// cfg_      write      wdata threshold_margin
//
// one sample beat per cycle while no result is stalled; the last sample of a
// bit period passes the sample register, accumulator and result register in turn
// a stalled result holds the whole pipe; in_tready = !out_tvalid || out_tready
// synchronous active-low reset clears sum, counter, floor; margin resets to 512
// ----------------------------------------------------------------------------
module ook_energy_bit_slicer_top import ooks_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // i_sample, q_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // bit_value, energy_average, floor_level
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_wdata
);

  logic [15:0]         margin_r;
  logic                en;
  ooks_avg_t           avg;
  logic                bit_value;
  logic [ENERGY_W-1:0] energy_average;
  logic [ENERGY_W-1:0] floor_level;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= 16'd512;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  ooks_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_beat  (in_tvalid && in_tready),
    .i_sample (in_tdata[7:0]),
    .q_sample (in_tdata[15:8]),
    .avg_o    (avg)
  );

  ooks_decide u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .margin         (margin_r),
    .avg_i          (avg),
    .res_valid      (out_tvalid),
    .bit_value      (bit_value),
    .energy_average (energy_average),
    .floor_level    (floor_level)
  );

  assign out_tdata = {7'd0, floor_level, energy_average, bit_value};

endmodule : ook_energy_bit_slicer_top
`default_nettype wire

// File: hw/rtl/ooks_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ooks_accum
// sample register, squared magnitude and per-bit energy accumulator
// ----------------------------------------------------------------------------
module ooks_accum import ooks_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_beat,
  input  wire logic signed [SAMPLE_W-1:0] i_sample,
  input  wire logic signed [SAMPLE_W-1:0] q_sample,
  output ooks_avg_t                       avg_o
);

  logic                       smp_valid_r;
  logic signed [SAMPLE_W-1:0] i_r;
  logic signed [SAMPLE_W-1:0] q_r;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       avg_valid_r;
  logic [ENERGY_W-1:0]        avg_val_r;
  ooks_avg_t                  avg_nxt;

  logic signed [MAG_W-1:0] ii;
  logic signed [MAG_W-1:0] qq;
  logic [MAG_W-1:0]        mag2;
  logic [SUM_W-1:0]        sum_add;

  always_comb begin
    ii      = MAG_W'(i_r) * MAG_W'(i_r);
    qq      = MAG_W'(q_r) * MAG_W'(q_r);
    mag2    = MAG_W'(ii) + MAG_W'(qq);
    sum_add = sum_r + SUM_W'(mag2);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    avg_nxt = '{valid: 1'b0, avg: avg_val_r};
    if (smp_valid_r) begin
      if (cnt_r == CNT_LAST) begin
        sum_nxt       = '0;
        cnt_nxt       = '0;
        avg_nxt.valid = 1'b1;
        avg_nxt.avg   = ENERGY_W'(sum_add / SUM_W'(SAMPLES_PER_BIT));
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      avg_valid_r <= 1'b0;
    end else if (en) begin
      smp_valid_r <= in_beat;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      avg_valid_r <= avg_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_r       <= i_sample;
      q_r       <= q_sample;
      avg_val_r <= avg_nxt.avg;
    end
  end

  assign avg_o = '{valid: avg_valid_r, avg: avg_val_r};

endmodule : ooks_accum
`default_nettype wire

// File: hw/rtl/ooks_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ooks_decide
// noise floor update, threshold compare and result register
// ----------------------------------------------------------------------------
module ooks_decide import ooks_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [15:0]         margin,
  input  wire ooks_avg_t           avg_i,
  output logic                     res_valid,
  output logic                     bit_value,
  output logic [ENERGY_W-1:0]      energy_average,
  output logic [ENERGY_W-1:0]      floor_level
);

  logic [ENERGY_W-1:0] floor_r, floor_nxt;
  logic                valid_r;
  logic                bit_r, bit_nxt;
  logic [ENERGY_W-1:0] avg_out_r;
  logic [FLOOR_W-1:0]  mix;
  logic [ENERGY_W:0]   thr;

  always_comb begin
    mix       = {floor_r, FLOOR_SH'(0)} - FLOOR_W'(floor_r) + FLOOR_W'(avg_i.avg);
    floor_nxt = ENERGY_W'(mix >> FLOOR_SH);
    thr       = {1'b0, floor_nxt} + {1'b0, margin};
    bit_nxt   = ({1'b0, avg_i.avg} > thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      floor_r <= '0;
    end else if (en) begin
      valid_r <= avg_i.valid;
      if (avg_i.valid) begin
        floor_r <= floor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && avg_i.valid) begin
      bit_r     <= bit_nxt;
      avg_out_r <= avg_i.avg;
    end
  end

  assign res_valid      = valid_r;
  assign bit_value      = bit_r;
  assign energy_average = avg_out_r;
  assign floor_level    = floor_r;

endmodule : ooks_decide
`default_nettype wire

// File: hw/rtl/ooks_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ooks_checker
// port-level checks on the ook energy bit slicer
// ----------------------------------------------------------------------------
module ooks_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped under stall");

  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed under stall");

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("padding bits set");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:1] <= 16'd32768 && out_tdata[32:17] <= 16'd32768)
    else $error("energy or floor above the largest magnitude");

endmodule : ooks_checker

bind ook_energy_bit_slicer_top ooks_checker u_ooks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
